// File: rtl/rtlm_pkg.sv
// Types and constants shared by the reply timing link monitor.
package rtlm_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LIMIT_W    = 42;
  localparam int unsigned LAT_W      = 23;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SUCCESSES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY     = 2'd2;

  localparam logic [31:0] CYCLE_AGE_LIMIT     = 32'd1;
  localparam logic [31:0] WAVEFORM_WAIT_LIMIT = 32'd100;
  localparam logic [9:0]  LATENCY_DIVISOR     = 10'd1000;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [28:0] RECIP_1000  = 29'd274877907;

  // Input item; packed MSB first, so the first field lands in the high bits
  typedef struct packed {
    logic [15:0] acked_waveform_id;
    logic [31:0] reply_cycle;
    logic [63:0] reply_time;
    logic [15:0] sent_waveform_id;
    logic [31:0] network_cycle;
    logic [63:0] command_time;
  } in_item_t;

  typedef struct packed {
    logic             link_down;
    logic [31:0]      waveform_late_count;
    logic [31:0]      late_count;
    logic [31:0]      on_time_count;
    logic [LAT_W-1:0] latency;
  } out_item_t;

  typedef struct packed {
    logic [15:0] last_acked_waveform;
    logic [31:0] waveform_start_cycle;
    logic [31:0] on_time_counter;
    logic [31:0] late_counter;
    logic [31:0] waveform_late_counter;
    logic        link_state;
  } mon_state_t;

  // delay_limit holds max_delay * 1000 + 999: latency > max_delay iff diff > delay_limit
  typedef struct packed {
    logic [31:0]        max_failures;
    logic [31:0]        min_successes;
    logic [LIMIT_W-1:0] delay_limit;
  } mon_cfg_t;

endpackage

// File: rtl/reply_timing_link_monitor.sv
// Top level of the reply timing link monitor: stream ports, registers and state.
//
// Takes one item per control cycle on the s_ stream and returns one result per
// item on the m_ stream, in order. The reply latency is the low 32 bits of
// reply_time - command_time divided by 1000; a reply is late when it is more
// than one network cycle old, slower than max_delay, or when a waveform has
// been waiting unacknowledged past WAVEFORM_WAIT_LIMIT. Late and on-time
// counters move link_down between connected and disconnected with hysteresis
// set by max_failures and min_successes. Throughput is one item per clock
// while m_tready holds high; an item passes through the input register and
// then the result register on its way to the m_ stream. The loop that sets
// this rate is the state update, done combinationally from the input
// register into the state and result registers, with the divide by 1000
// done as one reciprocal multiply alongside it. Configuration is to be
// written on cfg_we/cfg_index/cfg_data only while no item is in flight; the
// block does not enforce this. Indexes beyond max_delay are ignored. Nothing
// needs clearing after reset beyond the registers that reset clears at once.
module reply_timing_link_monitor import rtlm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata, low bit up: command_time[63:0], network_cycle[95:64],
  // sent_waveform_id[111:96], reply_time[175:112], reply_cycle[207:176],
  // acked_waveform_id[223:208]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [223:0]          s_tdata,
  // m_tdata, low bit up: latency[22:0], on_time_count[54:23],
  // late_count[86:55], waveform_late_count[118:87], link_down[119]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [119:0]          m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  in_item_t   in_reg;
  logic       in_valid;
  out_item_t  out_reg;
  logic       out_valid;
  mon_state_t state;
  mon_state_t state_next;
  mon_cfg_t   cfg;
  out_item_t  result;
  logic       out_free;
  logic       advance;

  // result register frees up when empty or when it is taken this cycle
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg;

  rtlm_core u_core (
    .item       (in_reg),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result)
  );

  // control, state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid          <= 1'b0;
      out_valid         <= 1'b0;
      state             <= '0;
      cfg.max_failures  <= '0;
      cfg.min_successes <= '0;
      cfg.delay_limit   <= LIMIT_W'(LATENCY_DIVISOR - 10'd1);
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
      if (advance) begin
        state <= state_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_FAILURES:  cfg.max_failures  <= cfg_data;
          REG_MIN_SUCCESSES: cfg.min_successes <= cfg_data;
          REG_MAX_DELAY: begin
            // delay_limit is the largest diff whose latency is still within max_delay
            cfg.delay_limit <= LIMIT_W'(cfg_data) * LIMIT_W'(LATENCY_DIVISOR)
                               + LIMIT_W'(LATENCY_DIVISOR - 10'd1);
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_reg <= in_item_t'(s_tdata);
    end
    if (advance) begin
      out_reg <= result;
    end
  end

  // state moves only with an item
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("monitor state changed without an item");

  // reconnection clears the late counters
  a_reconnect_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(state.link_state) |-> (state.late_counter == 32'd0) &&
                                (state.waveform_late_counter == 32'd0))
    else $error("late counters not cleared on reconnection");

  // the link only drops on a late reply, which clears the on-time run
  a_drop_clears_run: assert property (@(posedge clk) disable iff (rst)
    $rose(state.link_state) |-> state.on_time_counter == 32'd0)
    else $error("on-time counter not cleared when link dropped");

  // an item processed this cycle shows up as a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid && (m_tdata[119] == state.link_state))
    else $error("result missing or out of step with link state");

endmodule

// File: rtl/rtlm_core.sv
// Per-item latency check and link state update.
module rtlm_core import rtlm_pkg::*; (
  input  in_item_t   item,
  input  mon_state_t state,
  input  mon_cfg_t   cfg,
  output mon_state_t state_next,
  output out_item_t  result
);

  logic [31:0]  diff;
  logic [60:0]  prod;
  logic [31:0]  age;
  logic         late_reply;
  logic         late;
  logic [31:0]  start_eff;
  logic [31:0]  wait_cycles;
  logic [31:0]  late_inc;
  logic [31:0]  on_time_inc;

  // only the low 32 bits of the timestamp difference matter
  assign diff = item.reply_time[31:0] - item.command_time[31:0];
  assign prod = 61'(diff) * 61'(RECIP_1000);
  assign age  = item.network_cycle - item.reply_cycle;

  assign late_reply = (age > CYCLE_AGE_LIMIT) ||
                      ({{(LIMIT_W-32){1'b0}}, diff} > cfg.delay_limit);

  assign start_eff   = (state.waveform_start_cycle == 32'd0) ? item.network_cycle
                                                            : state.waveform_start_cycle;
  assign wait_cycles = item.network_cycle - start_eff;
  assign late_inc    = state.late_counter + 32'd1;
  assign on_time_inc = state.on_time_counter + 32'd1;

  always_comb begin
    state_next = state;
    late       = late_reply;

    if (!late_reply && (item.sent_waveform_id != state.last_acked_waveform)) begin
      late = wait_cycles > WAVEFORM_WAIT_LIMIT;
      if (item.sent_waveform_id == item.acked_waveform_id) begin
        state_next.last_acked_waveform  = item.sent_waveform_id;
        state_next.waveform_start_cycle = 32'd0;
      end else begin
        state_next.waveform_start_cycle = start_eff;
      end
      if (late) begin
        state_next.waveform_late_counter = state.waveform_late_counter + 32'd1;
      end
    end

    if (late) begin
      state_next.late_counter    = late_inc;
      state_next.on_time_counter = 32'd0;
      if (late_inc > cfg.max_failures) begin
        state_next.link_state = 1'b1;
      end
    end else if (state.link_state) begin
      state_next.on_time_counter = on_time_inc;
      if (on_time_inc > cfg.min_successes) begin
        state_next.link_state            = 1'b0;
        state_next.late_counter          = 32'd0;
        state_next.waveform_late_counter = 32'd0;
      end
    end
  end

  assign result.latency             = prod[RECIP_SHIFT +: LAT_W];
  assign result.on_time_count       = state_next.on_time_counter;
  assign result.late_count          = state_next.late_counter;
  assign result.waveform_late_count = state_next.waveform_late_counter;
  assign result.link_down           = state_next.link_state;

endmodule

// File: verif/reply_timing_link_monitor_test.sv
// Self-checking testbench for the reply timing link monitor.
`timescale 1ns / 100ps

module reply_timing_link_monitor_test;
  import rtlm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // no register here: writes are dropped
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 90;           // long enough to back up the input

  // Expected-result model: registers, monitor state and the queue of pending reports.
  class link_health_predictor;
    logic [31:0] max_failures, min_successes, max_delay;
    logic [15:0] last_acked;
    logic [31:0] wave_start, on_time_cnt, late_cnt, wave_late_cnt;
    logic        link_dn;
    out_item_t   expected_reports[$];
    int unsigned mismatches, reports_checked, down_reports;

    function void clear();
      max_failures = '0; min_successes = '0; max_delay = '0;
      last_acked = '0; wave_start = '0;
      on_time_cnt = '0; late_cnt = '0; wave_late_cnt = '0;
      link_dn = 1'b0;
      expected_reports.delete();
      mismatches = 0; reports_checked = 0; down_reports = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_MAX_FAILURES:  max_failures = val;
        REG_MIN_SUCCESSES: min_successes = val;
        REG_MAX_DELAY:     max_delay = val;
        default: ;
      endcase
    endfunction

    function void note_item(in_item_t it);
      logic [63:0] span;
      logic [31:0] lat, age, wait_len;
      logic        late;
      out_item_t   rep;
      span = it.reply_time - it.command_time;
      lat  = span[31:0] / LATENCY_DIVISOR;
      age  = it.network_cycle - it.reply_cycle;
      late = age > CYCLE_AGE_LIMIT;
      if (!late) late = lat > max_delay;
      if (!late && it.sent_waveform_id != last_acked) begin
        // a wait starting on cycle zero records zero, i.e. nothing pending
        if (wave_start == '0) wave_start = it.network_cycle;
        wait_len = it.network_cycle - wave_start;
        late = wait_len > WAVEFORM_WAIT_LIMIT;
        if (it.sent_waveform_id == it.acked_waveform_id) begin
          last_acked = it.sent_waveform_id;
          wave_start = '0;
        end
        if (late) wave_late_cnt = wave_late_cnt + 32'd1;
      end
      if (late) begin
        late_cnt = late_cnt + 32'd1;
        on_time_cnt = '0;
        if (late_cnt > max_failures) link_dn = 1'b1;
      end else if (link_dn) begin
        on_time_cnt = on_time_cnt + 32'd1;
        if (on_time_cnt > min_successes) begin
          link_dn = 1'b0;
          late_cnt = '0;
          wave_late_cnt = '0;
        end
      end
      rep.latency             = lat[LAT_W-1:0];
      rep.on_time_count       = on_time_cnt;
      rep.late_count          = late_cnt;
      rep.waveform_late_count = wave_late_cnt;
      rep.link_down           = link_dn;
      expected_reports.push_back(rep);
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        $error("result with no item outstanding: %h", got);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      reports_checked++;
      if (got.link_down) down_reports++;
      if (got.latency !== want.latency) begin
        $error("latency: expected %0d, got %0d", want.latency, got.latency);
        mismatches++;
      end
      if (got.on_time_count !== want.on_time_count) begin
        $error("on_time_count: expected %0d, got %0d", want.on_time_count, got.on_time_count);
        mismatches++;
      end
      if (got.late_count !== want.late_count) begin
        $error("late_count: expected %0d, got %0d", want.late_count, got.late_count);
        mismatches++;
      end
      if (got.waveform_late_count !== want.waveform_late_count) begin
        $error("waveform_late_count: expected %0d, got %0d",
               want.waveform_late_count, got.waveform_late_count);
        mismatches++;
      end
      if (got.link_down !== want.link_down) begin
        $error("link_down: expected %0d, got %0d", want.link_down, got.link_down);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_reports.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [223:0]          s_tdata;   // command_time, network_cycle, sent_waveform_id,
                                    // reply_time, reply_cycle, acked_waveform_id
  logic                  m_tvalid;
  logic                  m_tready;
  logic [119:0]          m_tdata;   // latency, on_time_count, late_count,
                                    // waveform_late_count, link_down
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  reply_timing_link_monitor u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  link_health_predictor health = new();

  int unsigned cycles;
  int unsigned items_sent;
  int unsigned settings_run;
  bit          calm;       // no gaps on either side while set
  bit          hold_long;  // one-shot request for a long receiver stall

  // traffic generator state: a running network cycle and the waveform in flight
  logic [31:0] run_cycle;
  logic [15:0] wave_id, prev_wave_id;
  int unsigned wave_age, wave_target;
  bit          wave_acked;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
  end

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL reply_timing_link_monitor");
      $finish;
    end
  end

  // Both handshakes are sampled on the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) health.note_item(in_item_t'(s_tdata));
    if (!rst && m_tvalid && m_tready) health.check_report(out_item_t'(m_tdata));
  end

  // Receiver: random stall per item, the odd long hold-off, none while calm.
  initial begin : receiver
    int unsigned gap;
    int unsigned held;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 9);
      if (hold_long) begin
        hold_long = 1'b0;
        gap = LONG_HOLD;
      end
      if (gap != 0) begin
        m_tready <= 1'b0;
        held = 0;
        while (held < gap) begin
          @(negedge clk);
          held++;
        end
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic in_item_t make_item(logic [63:0] ct, logic [31:0] nc, logic [15:0] sid,
                                         logic [63:0] rt, logic [31:0] rc, logic [15:0] aid);
    in_item_t it;
    it.command_time      = ct;
    it.network_cycle     = nc;
    it.sent_waveform_id  = sid;
    it.reply_time        = rt;
    it.reply_cycle       = rc;
    it.acked_waveform_id = aid;
    return it;
  endfunction

  // Offer one item after a random gap; returns on the falling edge after acceptance.
  task automatic offer_item(in_item_t it);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= it;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Called on a falling edge; returns on one with nothing in flight.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (health.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);  // result path is two registers deep
  endtask

  // Registers go in only with the block idle; the unused index is hit every time.
  task automatic program_limits(logic [31:0] mf, logic [31:0] ms, logic [31:0] md);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [31:0]          val [4];
    idx = '{REG_UNUSED, REG_MAX_FAILURES, REG_MIN_SUCCESSES, REG_MAX_DELAY};
    val = '{$urandom, mf, ms, md};
    wait_drained();
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      health.write_reg(idx[k], val[k]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_run++;
  endtask

  // Mostly well-formed traffic: cycles advancing, replies fresh, waveforms acked
  // after a short or a long wait; a small share of pure noise.
  task automatic next_traffic_item(output in_item_t it);
    logic [63:0] lim64, ct, rt;
    logic [31:0] lim, delta, rc;
    logic [15:0] aid;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it = make_item({$urandom, $urandom}, $urandom, 16'($urandom), {$urandom, $urandom},
                     $urandom, 16'($urandom));
      return;
    end
    run_cycle = (pick < 12) ? $urandom : run_cycle + 32'd1;
    pick = $urandom_range(0, 99);
    rc = run_cycle - ((pick < 90) ? $urandom_range(0, 1) : $urandom_range(2, 5));
    if (pick == 99) rc = run_cycle + 32'd1;
    lim64 = {32'd0, health.max_delay} * 64'd1000 + 64'd999;
    lim = (lim64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lim64[31:0];
    pick = $urandom_range(0, 99);
    if (lim == 32'hFFFF_FFFF || pick < 80) delta = $urandom_range(0, lim);
    else if (pick < 90) delta = lim + $urandom_range(0, 1);
    else delta = $urandom;
    ct = {$urandom, $urandom};
    rt = ct + {(($urandom_range(0, 3) == 0) ? $urandom : 32'd0), delta};
    if (wave_acked && $urandom_range(0, 4) == 0) begin
      prev_wave_id = wave_id;
      wave_id = 16'($urandom);
      wave_age = 0;
      wave_target = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 10) : $urandom_range(95, 130);
      wave_acked = 1'b0;
    end
    if (!wave_acked && wave_age >= wave_target) wave_acked = 1'b1;
    aid = wave_acked ? wave_id : prev_wave_id;
    wave_age++;
    it = make_item(ct, run_cycle, wave_id, rt, rc, aid);
  endtask

  task automatic run_traffic(int unsigned count, int unsigned stall_at, int unsigned drain_at);
    in_item_t it;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == stall_at) hold_long = 1'b1;  // sender carries on into the stall
      if (n == drain_at) wait_drained();
      next_traffic_item(it);
      offer_item(it);
    end
  endtask

  initial begin : stimulus
    in_item_t directed [$];
    cycles = 0;
    items_sent = 0;
    settings_run = 0;
    calm = 1'b0;
    hold_long = 1'b0;
    health.clear();
    run_cycle = $urandom;
    wave_id = '0;
    prev_wave_id = '0;
    wave_age = 0;
    wave_target = 0;
    wave_acked = 1'b1;

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: timestamp and cycle extremes and wraps, latency boundary,
    // link going down and back up, waveform waits including one from cycle zero.
    program_limits(32'd2, 32'd1, 32'd5);
    directed.push_back(make_item('0, '0, '0, '0, '0, '0));
    directed.push_back(make_item('1, 32'd1, '0, '0, 32'd1, '0));      // reply before command
    directed.push_back(make_item('0, 32'd2, '0, '1, 32'd1, '0));      // largest latency
    directed.push_back(make_item(64'd1000, 32'd3, '0, 64'd6999, 32'd3, '0)); // latency at limit
    directed.push_back(make_item(64'd5, 32'd4, '0, 64'd6005, 32'd3, '0));    // one past limit
    directed.push_back(make_item('0, 32'd5, '0, '0, 32'd3, '0));      // reply older than the age limit
    directed.push_back(make_item('0, 32'd0, '0, '0, '1, '0));         // cycle wrap, one old
    directed.push_back(make_item('0, 32'd10, '0, '0, 32'd11, '0));    // reply from the future
    directed.push_back(make_item('0, 32'd11, '0, '0, 32'd11, '0));
    directed.push_back(make_item('0, 32'd12, '0, '0, 32'd12, '0));
    directed.push_back(make_item('0, 32'd0, 16'd7, '0, 32'd0, '0));   // wait starts on cycle zero
    directed.push_back(make_item('0, 32'd50, 16'd7, '0, 32'd50, '0));
    directed.push_back(make_item('0, 32'd151, 16'd7, '0, 32'd151, '0));
    directed.push_back(make_item('0, 32'd150, 16'd7, '0, 32'd150, '0));  // wait exactly 100
    directed.push_back(make_item('0, 32'd152, 16'd7, '0, 32'd151, 16'd7));
    directed.push_back(make_item('0, 32'd153, 16'd7, '0, 32'd153, '0));
    directed.push_back(make_item('0, '1, '1, '0, 32'hFFFF_FFFE, '1));
    directed.push_back(make_item(64'h8000_0000_0000_0000, 32'd1, 16'h8000,
                                 64'h9234_5678_0000_0100, 32'd1, '0));
    directed.push_back(make_item('0, 32'd102, 16'h8000, '0, 32'd101, '0));
    directed.push_back(make_item({32{2'b10}}, 32'h5555_5555, 16'h5555, {32{2'b01}},
                                 32'hAAAA_AAAA, 16'hAAAA));
    foreach (directed[k]) offer_item(directed[k]);

    // Random traffic across several register settings, extremes included.
    program_limits(32'd3, 32'd2, 32'd40);
    run_traffic(140, 60, 200);                       // long receiver stall
    program_limits(32'd0, 32'd0, 32'd0);
    run_traffic(140, 200, 200);
    program_limits('1, '1, '1);
    calm = 1'b1;                                     // back-to-back stretch
    run_traffic(70, 200, 200);
    calm = 1'b0;
    run_traffic(70, 200, 200);
    program_limits(32'd6, 32'd4, 32'd4294967);
    run_traffic(140, 200, 70);                       // sender waits for all results
    program_limits($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 2000));
    run_traffic(140, 30, 200);

    wait_drained();
    repeat (10) @(negedge clk);
    $display("Sent %0d items over %0d register settings; %0d results checked, %0d link down.",
             items_sent, settings_run, health.reports_checked, health.down_reports);
    if (health.mismatches == 0 && health.outstanding() == 0) begin
      $display("PASS reply_timing_link_monitor");
    end else begin
      $display("FAIL reply_timing_link_monitor");
    end
    $finish;
  end

endmodule
